// File: src/assembler_line_field_splitter_defines.svh
// Assertion macros for the line field splitter.
`ifndef ASSEMBLER_LINE_FIELD_SPLITTER_DEFINES_SVH
`define ASSEMBLER_LINE_FIELD_SPLITTER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define LSF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("lsf: assertion failed");
`define LSF_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("lsf: invariant failed");
`else
`define LSF_ASSERT(lbl, prop)
`define LSF_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// File: src/lsf_pkg.sv
`timescale 1ns / 1ps

package lsf_pkg;

  localparam int unsigned PhaseW = 3;

  localparam logic [PhaseW-1:0] PH_START  = 3'd0;
  localparam logic [PhaseW-1:0] PH_LABEL  = 3'd1;
  localparam logic [PhaseW-1:0] PH_SKIP1  = 3'd2;
  localparam logic [PhaseW-1:0] PH_MNEM   = 3'd3;
  localparam logic [PhaseW-1:0] PH_SKIP2  = 3'd4;
  localparam logic [PhaseW-1:0] PH_EQSKIP = 3'd5;
  localparam logic [PhaseW-1:0] PH_OPER   = 3'd6;
  localparam logic [PhaseW-1:0] PH_DONE   = 3'd7;

  localparam logic [1:0] FID_LABEL = 2'd0;
  localparam logic [1:0] FID_MNEM  = 2'd1;
  localparam logic [1:0] FID_OPER  = 2'd2;

  localparam logic [1:0] MARK_CHAR  = 2'd0;
  localparam logic [1:0] MARK_BREAK = 2'd1;
  localparam logic [1:0] MARK_EOL   = 2'd2;

  typedef struct packed {
    logic [1:0] field_id;
    logic [1:0] mark;
    logic [7:0] char_out;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [PhaseW-1:0] phase;
    logic              sq;
    logic              dq;
    logic              esc;
    logic              skip;
  } state_t;

endpackage

// File: src/lsf_in_if.sv
`timescale 1ns / 1ps

interface lsf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       line_end;

  modport source (output valid, output char_in, output line_end, input ready);
  modport sink (input valid, input char_in, input line_end, output ready);
endinterface

// File: src/lsf_out_if.sv
`timescale 1ns / 1ps

interface lsf_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] field_id;
  logic [1:0] mark;
  logic [7:0] char_out;
  logic       last;

  modport source (
    output valid, output field_id, output mark, output char_out, output last,
    input ready
  );
  modport sink (
    input valid, input field_id, input mark, input char_out, input last,
    output ready
  );
endinterface

// File: src/lsf_step.sv
`timescale 1ns / 1ps

module lsf_step import lsf_pkg::*; #(
  parameter int unsigned ANGLE_LIMIT = 63
) (
  input  state_t                                      st_i,
  input  logic signed [$clog2(ANGLE_LIMIT+1):0]       depth_i,
  input  logic [7:0]                                  c_i,
  input  logic                                        line_end_i,
  input  logic                                        angle_en_i,
  output state_t                                      st_o,
  output logic signed [$clog2(ANGLE_LIMIT+1):0]       depth_o,
  output logic [1:0]                                  n_o,
  output res_t                                        res0_o,
  output res_t                                        res1_o
);

  localparam int unsigned DepthW = $clog2(ANGLE_LIMIT + 1) + 1;
  localparam logic signed [DepthW-1:0] DepthMax = DepthW'(ANGLE_LIMIT);
  localparam logic signed [DepthW-1:0] DepthMin = -DepthMax;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_TILDE = 8'h7E;

  function automatic logic is_ws(logic [7:0] c);
    return c inside {[8'd9:8'd13], CH_SPACE};
  endfunction

  function automatic logic [7:0] upcase(logic [7:0] c);
    return (c inside {[8'h61:8'h7A]}) ? c - 8'd32 : c;
  endfunction

  function automatic res_t mk(logic [1:0] f, logic [1:0] m, logic [7:0] ch, logic l);
    res_t r;
    r.field_id = f;
    r.mark     = m;
    r.char_out = ch;
    r.last     = l;
    return r;
  endfunction

  logic                     ws;
  // operand path
  state_t                   op_st;
  logic signed [DepthW-1:0] op_depth;
  logic                     op_emit;
  res_t                     op_res;
  logic                     op_done;
  logic                     op_bal;
  // main path
  state_t                   mn_st;
  logic signed [DepthW-1:0] mn_depth;
  logic                     pre_emit;
  res_t                     pre_res;
  logic                     use_op;
  logic                     sp_emit;

  assign ws = is_ws(c_i);

  always_comb begin
    op_st    = st_i;
    op_depth = depth_i;
    op_emit  = 1'b0;
    op_res   = mk(FID_OPER, MARK_CHAR, c_i, 1'b0);
    op_done  = 1'b0;
    op_bal   = 1'b0;
    if (st_i.esc) begin
      op_st.esc = 1'b0;
      op_emit   = 1'b1;
      if (c_i == CH_NUL) begin
        op_done         = 1'b1;
        op_res.char_out = CH_SPACE;
      end
    end else if (st_i.skip && ws) begin
      op_emit = 1'b0;
    end else begin
      op_st.skip = 1'b0;
      if (c_i == CH_NUL) begin
        op_done = 1'b1;
      end else if (c_i == CH_TILDE) begin
        op_st.esc = 1'b1;
      end else if (c_i == CH_SEMI && !st_i.sq && !st_i.dq) begin
        op_done = 1'b1;
      end else begin
        op_st.sq = st_i.sq ^ (c_i == CH_SQ && !st_i.dq);
        op_st.dq = st_i.dq ^ (c_i == CH_DQ && !op_st.sq);
        if (!op_st.sq && !op_st.dq) begin
          if (c_i == CH_LT && depth_i < DepthMax) op_depth = depth_i + DepthW'(1);
          if (c_i == CH_GT && depth_i > DepthMin) op_depth = depth_i - DepthW'(1);
        end
        op_bal = !(angle_en_i && op_depth != '0) && !op_st.sq && !op_st.dq;
        if (op_bal && c_i == CH_COMMA) begin
          op_st.skip = 1'b1;
          op_emit    = 1'b1;
          op_res     = mk(FID_OPER, MARK_BREAK, 8'h00, 1'b0);
        end else if (op_bal && ws) begin
          op_done = 1'b1;
        end else begin
          op_emit = 1'b1;
        end
      end
    end
  end

  always_comb begin
    mn_st    = st_i;
    mn_depth = depth_i;
    pre_emit = 1'b0;
    pre_res  = mk(FID_LABEL, MARK_CHAR, upcase(c_i), 1'b0);
    use_op   = 1'b0;
    case (st_i.phase)
      PH_START, PH_LABEL: begin
        if (c_i == CH_NUL || (st_i.phase == PH_START && c_i == CH_SEMI)) begin
          mn_st.phase = PH_DONE;
        end else if (ws) begin
          mn_st.phase = PH_SKIP1;
        end else begin
          mn_st.phase = PH_LABEL;
          pre_emit    = 1'b1;
        end
      end
      PH_SKIP1: begin
        if (c_i == CH_NUL || c_i == CH_SEMI) begin
          mn_st.phase = PH_DONE;
        end else if (!ws) begin
          mn_st.phase      = PH_MNEM;
          pre_emit         = 1'b1;
          pre_res.field_id = FID_MNEM;
        end
      end
      PH_MNEM: begin
        if (c_i == CH_NUL) begin
          mn_st.phase = PH_DONE;
        end else if (ws) begin
          mn_st.phase = PH_SKIP2;
        end else begin
          pre_emit         = 1'b1;
          pre_res.field_id = FID_MNEM;
        end
      end
      PH_SKIP2: begin
        if (c_i == CH_NUL || c_i == CH_SEMI) begin
          mn_st.phase = PH_DONE;
        end else if (c_i == CH_EQ) begin
          mn_st.phase = PH_EQSKIP;
        end else if (!ws) begin
          use_op = 1'b1;
        end
      end
      PH_EQSKIP: begin
        if (!ws) use_op = 1'b1;
      end
      PH_OPER: begin
        use_op = 1'b1;
      end
      default: begin
        mn_st.phase = PH_DONE;
      end
    endcase
    if (use_op) begin
      mn_st       = op_st;
      mn_st.phase = op_done ? PH_DONE : PH_OPER;
      mn_depth    = op_depth;
      pre_emit    = op_emit;
      pre_res     = op_res;
    end
  end

  // a tilde left open at line end gives a space
  assign sp_emit = line_end_i && mn_st.phase == PH_OPER && mn_st.esc;

  always_comb begin
    n_o    = 2'(pre_emit) + 2'(sp_emit) + 2'(line_end_i);
    res0_o = pre_emit ? pre_res :
             (sp_emit ? mk(FID_OPER, MARK_CHAR, CH_SPACE, 1'b0)
                      : mk(FID_LABEL, MARK_EOL, 8'h00, 1'b1));
    res1_o = (pre_emit && sp_emit) ? mk(FID_OPER, MARK_CHAR, CH_SPACE, 1'b0)
                                   : mk(FID_LABEL, MARK_EOL, 8'h00, 1'b1);
    if (line_end_i) begin
      st_o.phase = PH_START;
      st_o.sq    = 1'b0;
      st_o.dq    = 1'b0;
      st_o.esc   = 1'b0;
      st_o.skip  = 1'b0;
      depth_o    = '0;
    end else begin
      st_o    = mn_st;
      depth_o = mn_depth;
    end
  end

endmodule

// File: src/assembler_line_field_splitter.sv
`timescale 1ns / 1ps
// Channel   Dir  Payload                               Transfer
// in_i      in   char_in[7:0], line_end                valid && ready
// out_o     out  field_id[1:0], mark[1:0], char_out[7:0], last
//                                                      valid && ready
// cfg       in   cfg_wdata_i (angle_enable)            cfg_we_i
//
// One byte is taken per cycle while in_i.ready is high; each byte gives zero, one or two results.
// Results go to a four-entry output queue; in_i.ready is high while the
// queue has room for two, so single-result bytes stream at one per cycle
// while out_o.ready is high and a two-result byte adds two queue entries.
// Results are registered in the queue before they appear on out_o.
// rst_ni clears line state, the queue and sets angle_enable to 1.

`include "assembler_line_field_splitter_defines.svh"

module assembler_line_field_splitter import lsf_pkg::*; #(
  parameter int unsigned ANGLE_LIMIT = 63
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_wdata_i,
  lsf_in_if.sink           in_i,
  lsf_out_if.source        out_o
);

  localparam int unsigned DepthW = $clog2(ANGLE_LIMIT + 1) + 1;

  logic                     angle_en_q;
  state_t                   st_q, st_d;
  logic signed [DepthW-1:0] depth_q, depth_d;
  logic [1:0]               n;
  res_t                     res0, res1;

  res_t                     fifo_q [4];
  logic [1:0]               wptr_q, rptr_q;
  logic [2:0]               cnt_q, cnt_d;
  logic                     in_fire, out_fire;
  res_t                     head;

  lsf_step #(
    .ANGLE_LIMIT(ANGLE_LIMIT)
  ) u_step (
    .st_i      (st_q),
    .depth_i   (depth_q),
    .c_i       (in_i.char_in),
    .line_end_i(in_i.line_end),
    .angle_en_i(angle_en_q),
    .st_o      (st_d),
    .depth_o   (depth_d),
    .n_o       (n),
    .res0_o    (res0),
    .res1_o    (res1)
  );

  assign in_i.ready = (cnt_q <= 3'd2);
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_fire   = out_o.valid && out_o.ready;

  assign head           = fifo_q[rptr_q];
  assign out_o.valid    = (cnt_q != 3'd0);
  assign out_o.field_id = head.field_id;
  assign out_o.mark     = head.mark;
  assign out_o.char_out = head.char_out;
  assign out_o.last     = head.last;

  always_comb begin
    cnt_d = cnt_q;
    if (in_fire) cnt_d = cnt_d + 3'(n);
    if (out_fire) cnt_d = cnt_d - 3'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_en_q <= 1'b1;
      st_q       <= '{phase: PH_START, default: 1'b0};
      depth_q    <= '0;
      wptr_q     <= '0;
      rptr_q     <= '0;
      cnt_q      <= '0;
    end else begin
      if (cfg_we_i) angle_en_q <= cfg_wdata_i;
      if (in_fire) begin
        st_q    <= st_d;
        depth_q <= depth_d;
        wptr_q  <= wptr_q + n;
      end
      if (out_fire) rptr_q <= rptr_q + 2'd1;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && n != 2'd0) fifo_q[wptr_q] <= res0;
    if (in_fire && n == 2'd2) fifo_q[wptr_q + 2'd1] <= res1;
  end

  `LSF_ASSERT_ALWAYS(a_queue_bound, !rst_ni || cnt_q <= 3'd4)
  `LSF_ASSERT(a_no_overflow, in_fire |-> (cnt_q + 3'(n)) <= 3'd4)
  `LSF_ASSERT(a_line_clear, in_fire && in_i.line_end |=> st_q.phase == PH_START && depth_q == '0)
  `LSF_ASSERT(a_eol_tag, out_o.valid && out_o.last |-> out_o.mark == MARK_EOL)

endmodule

// File: tb/assembler_line_field_splitter_tb.sv
`timescale 1ns / 1ps

module assembler_line_field_splitter_tb;
  import lsf_pkg::*;

  localparam int ANGLE_LIMIT     = 63;
  localparam int WATCHDOG_LIMIT  = 1000;
  localparam int SETTLE_CYCLES   = 8;
  localparam int ITEMS_PER_PHASE = 206;
  localparam int NUM_PHASES      = 5;
  localparam int REPORT_LIMIT    = 100;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_TILDE  = 8'h7E;

  class line_split_predictor;
    bit                angle_en;
    logic [PhaseW-1:0] phase;
    bit                in_sq;
    bit                in_dq;
    bit                esc_pending;
    bit                skip_ws;
    int                depth;
    res_t              field_q[$];
    int                mismatches;
    int                checked;

    function new();
      angle_en   = 1'b1;
      mismatches = 0;
      checked    = 0;
      clear_line();
    endfunction

    function void clear_line();
      phase       = PH_START;
      in_sq       = 1'b0;
      in_dq       = 1'b0;
      esc_pending = 1'b0;
      skip_ws     = 1'b0;
      depth       = 0;
    endfunction

    function bit is_ws(logic [7:0] c);
      return c == CH_SPACE || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function logic [7:0] upcase(logic [7:0] c);
      return (c >= "a" && c <= "z") ? c - 8'd32 : c;
    endfunction

    function void push(logic [1:0] fid, logic [1:0] mark, logic [7:0] ch, logic last);
      res_t r;
      r.field_id = fid;
      r.mark     = mark;
      r.char_out = ch;
      r.last     = last;
      field_q.push_back(r);
    endfunction

    function int pending();
      return field_q.size();
    endfunction

    function void operand_byte(logic [7:0] c);
      bit open;
      if (esc_pending) begin
        esc_pending = 1'b0;
        if (c == CH_NUL) begin
          phase = PH_DONE;
          push(FID_OPER, MARK_CHAR, CH_SPACE, 1'b0);
        end else begin
          push(FID_OPER, MARK_CHAR, c, 1'b0);
        end
        return;
      end
      if (skip_ws) begin
        if (is_ws(c)) return;
        skip_ws = 1'b0;
      end
      if (c == CH_NUL) begin
        phase = PH_DONE;
        return;
      end
      if (c == CH_TILDE) begin
        esc_pending = 1'b1;
        return;
      end
      if (c == CH_SEMI && !in_sq && !in_dq) begin
        phase = PH_DONE;
        return;
      end
      if (c == CH_SQUOTE && !in_dq) in_sq = !in_sq;
      if (c == CH_DQUOTE && !in_sq) in_dq = !in_dq;
      if (!in_sq && !in_dq) begin
        if (c == CH_LT && depth < ANGLE_LIMIT) depth++;
        if (c == CH_GT && depth > -ANGLE_LIMIT) depth--;
      end
      open = (angle_en && depth != 0) || in_sq || in_dq;
      if (!open && c == CH_COMMA) begin
        skip_ws = 1'b1;
        push(FID_OPER, MARK_BREAK, 8'h00, 1'b0);
        return;
      end
      if (!open && is_ws(c)) begin
        phase = PH_DONE;
        return;
      end
      push(FID_OPER, MARK_CHAR, c, 1'b0);
    endfunction

    function void take_byte(logic [7:0] c, logic le);
      case (phase)
        PH_START: begin
          if (c == CH_NUL || c == CH_SEMI) phase = PH_DONE;
          else if (is_ws(c)) phase = PH_SKIP1;
          else begin
            phase = PH_LABEL;
            push(FID_LABEL, MARK_CHAR, upcase(c), 1'b0);
          end
        end
        PH_LABEL: begin
          if (c == CH_NUL) phase = PH_DONE;
          else if (is_ws(c)) phase = PH_SKIP1;
          else push(FID_LABEL, MARK_CHAR, upcase(c), 1'b0);
        end
        PH_SKIP1: begin
          if (c == CH_NUL || c == CH_SEMI) phase = PH_DONE;
          else if (!is_ws(c)) begin
            phase = PH_MNEM;
            push(FID_MNEM, MARK_CHAR, upcase(c), 1'b0);
          end
        end
        PH_MNEM: begin
          if (c == CH_NUL) phase = PH_DONE;
          else if (is_ws(c)) phase = PH_SKIP2;
          else push(FID_MNEM, MARK_CHAR, upcase(c), 1'b0);
        end
        PH_SKIP2: begin
          if (c == CH_NUL || c == CH_SEMI) phase = PH_DONE;
          else if (c == CH_EQUAL) phase = PH_EQSKIP;
          else if (!is_ws(c)) begin
            phase = PH_OPER;
            operand_byte(c);
          end
        end
        PH_EQSKIP: begin
          if (!is_ws(c)) begin
            phase = PH_OPER;
            operand_byte(c);
          end
        end
        PH_OPER: operand_byte(c);
        default: phase = PH_DONE;
      endcase
      if (le) begin
        if (phase == PH_OPER && esc_pending) push(FID_OPER, MARK_CHAR, CH_SPACE, 1'b0);
        push(FID_LABEL, MARK_EOL, 8'h00, 1'b1);
        clear_line();
      end
    endfunction

    function void report(string name, int want, int got);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
    endfunction

    function void check_field(res_t got);
      res_t want;
      checked++;
      if (field_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $error("transfer with nothing expected: field_id %0d mark %0d char_out 0x%02h last %0d",
                 got.field_id, got.mark, got.char_out, got.last);
        return;
      end
      want = field_q.pop_front();
      if (got.field_id !== want.field_id) report("field_id", want.field_id, got.field_id);
      if (got.mark !== want.mark) report("mark", want.mark, got.mark);
      if (got.char_out !== want.char_out) report("char_out", want.char_out, got.char_out);
      if (got.last !== want.last) report("last", want.last, got.last);
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_wdata_i;

  lsf_in_if  in_bus ();
  lsf_out_if out_bus ();

  assembler_line_field_splitter #(
    .ANGLE_LIMIT(ANGLE_LIMIT)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (in_bus),
    .out_o      (out_bus)
  );

  line_split_predictor sb = new();

  logic [7:0] line_q[$];
  bit         idle_on;
  int         bytes_sent;
  int         bytes_seen;
  int         lines_seen;
  int         quiet_cycles;

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  always @(posedge clk_i) begin
    res_t got;
    bit   moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (in_bus.valid && in_bus.ready) begin
        sb.take_byte(in_bus.char_in, in_bus.line_end);
        bytes_seen++;
        if (in_bus.line_end) lines_seen++;
        moved = 1'b1;
      end
      if (out_bus.valid && out_bus.ready) begin
        got.field_id = out_bus.field_id;
        got.mark     = out_bus.mark;
        got.char_out = out_bus.char_out;
        got.last     = out_bus.last;
        sb.check_field(got);
        moved = 1'b1;
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no transfer for %0d cycles, %0d results outstanding",
                 quiet_cycles, sb.pending());
        $display("assembler_line_field_splitter: mismatch");
        $finish;
      end
    end
  end

  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (idle_on && $urandom_range(0, 9) == 0) begin
        out_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 18) - 1) @(negedge clk_i);
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  function automatic logic [7:0] rand_ws();
    int k;
    k = $urandom_range(0, 5);
    return (k == 5) ? CH_SPACE : 8'(9 + k);
  endfunction

  function automatic logic [7:0] rand_word();
    int k;
    k = $urandom_range(0, 19);
    if (k < 8) return 8'(8'h61 + $urandom_range(0, 25));
    if (k < 14) return 8'(8'h41 + $urandom_range(0, 25));
    if (k < 17) return 8'(8'h30 + $urandom_range(0, 9));
    if (k == 17) return 8'h24;
    if (k == 18) return 8'h23;
    return 8'($urandom_range(128, 255));
  endfunction

  function automatic logic [7:0] inner_char();
    int k;
    k = $urandom_range(0, 9);
    if (k < 4) return rand_word();
    if (k == 4) return CH_SPACE;
    if (k == 5) return CH_COMMA;
    if (k == 6) return CH_SEMI;
    if (k == 7) return $urandom_range(0, 1) ? CH_LT : CH_GT;
    if (k == 8) return $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
    return rand_ws();
  endfunction

  function automatic void add_operand_piece();
    logic [7:0] q;
    case ($urandom_range(0, 9))
      0, 1: repeat ($urandom_range(1, 4)) line_q.push_back(rand_word());
      2: begin
        q = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
        line_q.push_back(q);
        repeat ($urandom_range(0, 5)) line_q.push_back(inner_char());
        if ($urandom_range(0, 4) != 0) line_q.push_back(q);
      end
      3: begin
        line_q.push_back(CH_LT);
        repeat ($urandom_range(0, 5)) line_q.push_back(inner_char());
        if ($urandom_range(0, 6) != 0) line_q.push_back(CH_GT);
      end
      4: begin
        line_q.push_back(CH_COMMA);
        repeat ($urandom_range(0, 2)) line_q.push_back(rand_ws());
      end
      5: begin
        line_q.push_back(CH_TILDE);
        line_q.push_back($urandom_range(0, 5) == 0 ? CH_NUL : 8'($urandom_range(0, 255)));
      end
      6: line_q.push_back($urandom_range(0, 1) ? CH_LT : CH_GT);
      7: begin
        line_q.push_back(CH_SEMI);
        line_q.push_back(rand_word());
      end
      8: begin
        line_q.push_back(rand_ws());
        line_q.push_back(rand_word());
      end
      default: begin
        line_q.push_back(CH_SQUOTE);
        line_q.push_back(rand_word());
      end
    endcase
  endfunction

  function automatic void compose_line();
    int         kind;
    logic [7:0] b;
    line_q.delete();
    kind = $urandom_range(0, 99);
    if (kind < 6) begin
      // runs up to or past the angle depth limit in either direction
      b = $urandom_range(0, 1) ? CH_LT : CH_GT;
      line_q.push_back(CH_SPACE);
      line_q.push_back("x");
      line_q.push_back(CH_SPACE);
      repeat ($urandom_range(ANGLE_LIMIT - 2, ANGLE_LIMIT + 6)) line_q.push_back(b);
      line_q.push_back(CH_COMMA);
      line_q.push_back(CH_SPACE);
      line_q.push_back("y");
    end else if (kind < 22) begin
      repeat ($urandom_range(1, 20)) line_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      if ($urandom_range(0, 1)) repeat ($urandom_range(1, 6)) line_q.push_back(rand_word());
      repeat ($urandom_range(1, 3)) line_q.push_back(rand_ws());
      if ($urandom_range(0, 9) == 0) begin
        line_q.push_back(CH_SEMI);
        repeat ($urandom_range(0, 4)) line_q.push_back(rand_word());
      end else begin
        repeat ($urandom_range(1, 4)) line_q.push_back(rand_word());
        if ($urandom_range(0, 4) != 0) begin
          repeat ($urandom_range(1, 3)) line_q.push_back(rand_ws());
          if ($urandom_range(0, 5) == 0) begin
            line_q.push_back(CH_EQUAL);
            repeat ($urandom_range(0, 3)) line_q.push_back(rand_ws());
          end
          repeat ($urandom_range(1, 8)) add_operand_piece();
          if ($urandom_range(0, 4) == 0) begin
            line_q.push_back(rand_ws());
            line_q.push_back(CH_SEMI);
            line_q.push_back(rand_word());
          end
        end
      end
      if ($urandom_range(0, 24) == 0) begin
        line_q.push_back(CH_NUL);
        line_q.push_back(rand_word());
      end
      if ($urandom_range(0, 14) == 0) line_q.push_back(CH_TILDE);
    end
  endfunction

  function automatic void load_text(string s);
    line_q.delete();
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
  endfunction

  task automatic send_byte(input logic [7:0] c, input logic le);
    if (idle_on && $urandom_range(0, 11) == 0) begin
      @(negedge clk_i);
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 18) - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_bus.valid    <= 1'b1;
    in_bus.char_in  <= c;
    in_bus.line_end <= le;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_line();
    for (int i = 0; i < line_q.size(); i++) send_byte(line_q[i], i == line_q.size() - 1);
  endtask

  // drop valid, drain expected results, then give in-flight bytes time to retire
  task automatic settle();
    @(negedge clk_i);
    in_bus.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic program_angle(input logic v);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.angle_en = v;
  endtask

  initial begin
    int target;
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = 1'b0;
    in_bus.valid    = 1'b0;
    in_bus.char_in  = 8'h00;
    in_bus.line_end = 1'b0;
    idle_on         = 1'b1;
    bytes_sent      = 0;
    bytes_seen      = 0;
    lines_seen      = 0;
    quiet_cycles    = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    line_q = {CH_NUL};
    send_line();
    line_q = {CH_SEMI};
    send_line();
    load_text("z\t;");
    send_line();
    line_q = {8'hFF};
    send_line();
    load_text(" m = <a,b>, \"x \"~");
    send_line();

    target = bytes_sent;
    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      program_angle(1'(p % 2));
      idle_on = (p != 2) && (p != NUM_PHASES - 1);
      target += ITEMS_PER_PHASE;
      while (bytes_sent < target) begin
        compose_line();
        send_line();
      end
    end
    settle();

    $display("run: %0d bytes in %0d lines, %0d field transfers checked",
             bytes_seen, lines_seen, sb.checked);
    $display("run: directed lines then %0d random phases, angle_enable alternating 0 and 1",
             NUM_PHASES);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("assembler_line_field_splitter: match");
    end else begin
      $display("assembler_line_field_splitter: mismatch");
    end
    $finish;
  end

endmodule

// File: assembler_line_field_splitter.f
+incdir+src
src/lsf_pkg.sv
src/lsf_in_if.sv
src/lsf_out_if.sv
src/lsf_step.sv
src/assembler_line_field_splitter.sv
tb/assembler_line_field_splitter_tb.sv
